// File: hdl/look_at_view_matrix_defines.svh
// ----------------------------------------------------------------------------
// Look-at view matrix: assertion macros
// Shared concurrent assertion forms for the block's modules.
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define LAVM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define LAVM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/lavm_pkg.sv
// ----------------------------------------------------------------------------
// Look-at view matrix: package
// Widths, row codes, shared types and rounding helpers.
// ----------------------------------------------------------------------------
package lavm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    // unit axis component, magnitude up to 1.0
    localparam int UNIT_W    = FRAC_BITS + 2;
    // true up component, magnitude up to 2.0
    localparam int UP_W      = FRAC_BITS + 3;
    // normalizer input (cross product at full precision)
    localparam int NV_W      = FRAC_BITS + 35;
    localparam int BL_W      = $clog2(NV_W + 1);
    // scaled magnitude, top bit at 2^29
    localparam int MN_W      = 30;
    localparam int SQ_W      = 64;
    localparam int ROOT_W    = 31;
    localparam int SQ_STEPS  = ROOT_W;
    localparam int NUM_W     = MN_W + 1 + FRAC_BITS;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int DOT_W     = FRAC_BITS + 37;
    localparam int RND_W     = DOT_W + 1;

    localparam logic [1:0] ROW_X    = 2'd0;
    localparam logic [1:0] ROW_Y    = 2'd1;
    localparam logic [1:0] ROW_Z    = 2'd2;
    localparam logic [1:0] ROW_LAST = 2'd3;

    typedef logic [2:0][NV_W-1:0]   nvec_t;
    typedef logic [2:0][UNIT_W-1:0] uvec_t;

    typedef struct packed {
        logic                   ok;
        logic [2:0][WORD_W-1:0] eye;
        logic [2:0][WORD_W-1:0] aux;
    } side_t;

    // Shift right by FRAC_BITS, rounding half away from zero
    function automatic logic signed [RND_W-1:0] rnd_shift(input logic signed [DOT_W-1:0] v);
        logic signed [RND_W-1:0] vx;
        logic signed [RND_W-1:0] half;
        logic signed [RND_W-1:0] a;
        logic signed [RND_W-1:0] r;
        vx = RND_W'(v);
        half = '0;
        half[FRAC_BITS-1] = 1'b1;
        if (v < 0) begin
            a = half - vx;
        end else begin
            a = vx + half;
        end
        r = a >>> FRAC_BITS;
        return (v < 0) ? -r : r;
    endfunction

    // Negate the rounded value and clamp to the signed word range
    function automatic logic [WORD_W-1:0] neg_sat(input logic signed [DOT_W-1:0] v);
        logic signed [RND_W:0] n;
        n = -((RND_W + 1)'(rnd_shift(v)));
        if ((&n[RND_W:WORD_W-1]) || !(|n[RND_W:WORD_W-1])) begin
            return n[WORD_W-1:0];
        end else if (n[RND_W]) begin
            return {1'b1, {(WORD_W - 1){1'b0}}};
        end else begin
            return {1'b0, {(WORD_W - 1){1'b1}}};
        end
    endfunction

endpackage

// File: hdl/lavm_norm.sv
// ----------------------------------------------------------------------------
// Look-at view matrix: vector normalizer
// Pipelined scale, sum of squares, bit-per-stage square root and
// bit-per-stage division of three components by the length.
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_defines.svh"

module lavm_norm (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  lavm_pkg::nvec_t in_vec,
    input  lavm_pkg::side_t in_side,
    output logic            out_valid,
    output lavm_pkg::uvec_t out_unit,
    output logic            out_ok,
    output lavm_pkg::side_t out_side
);

    localparam int NV_W   = lavm_pkg::NV_W;
    localparam int BL_W   = lavm_pkg::BL_W;
    localparam int MN_W   = lavm_pkg::MN_W;
    localparam int SQ_W   = lavm_pkg::SQ_W;
    localparam int ROOT_W = lavm_pkg::ROOT_W;
    localparam int SQ_N   = lavm_pkg::SQ_STEPS;
    localparam int NUM_W  = lavm_pkg::NUM_W;
    localparam int Q_W    = lavm_pkg::Q_W;
    localparam int UNIT_W = lavm_pkg::UNIT_W;
    localparam int FB     = lavm_pkg::FRAC_BITS;

    typedef struct packed {
        logic [2:0][MN_W-1:0] mn;
        logic [2:0]           neg;
        logic                 zero;
        lavm_pkg::side_t      side;
    } car_t;

    function automatic logic [BL_W-1:0] bit_len(input logic [NV_W-1:0] x);
        logic [BL_W-1:0] n;
        n = '0;
        for (int i = 0; i < NV_W; i++) begin
            if (x[i]) begin
                n = BL_W'(i + 1);
            end
        end
        return n;
    endfunction

    // Stage 1: magnitudes and signs
    logic                 v1_reg;
    logic [2:0][NV_W-1:0] mag1_reg;
    logic [2:0]           neg1_reg;
    lavm_pkg::side_t      side1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                neg1_reg[i] <= in_vec[i][NV_W-1];
                mag1_reg[i] <= in_vec[i][NV_W-1] ? -in_vec[i] : in_vec[i];
            end
            side1_reg <= in_side;
        end
    end

    // Stage 2: bit length of the largest magnitude
    logic                 v2_reg;
    logic [2:0][NV_W-1:0] mag2_reg;
    logic [2:0]           neg2_reg;
    logic [BL_W-1:0]      bl2_reg;
    lavm_pkg::side_t      side2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            bl2_reg   <= bit_len(mag1_reg[0] | mag1_reg[1] | mag1_reg[2]);
            side2_reg <= side1_reg;
        end
    end

    // Stage 3: common shift so the largest lands in [2^29, 2^30)
    logic                 v3_reg;
    car_t                 car3_reg;
    logic [2:0][MN_W-1:0] mn3_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (bl2_reg > BL_W'(MN_W)) begin
                mn3_next[i] = MN_W'(mag2_reg[i] >> (bl2_reg - BL_W'(MN_W)));
            end else begin
                mn3_next[i] = MN_W'(mag2_reg[i] << (BL_W'(MN_W) - bl2_reg));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            car3_reg.mn   <= mn3_next;
            car3_reg.neg  <= neg2_reg;
            car3_reg.zero <= (bl2_reg == '0);
            car3_reg.side <= side2_reg;
        end
    end

    // Stage 4: squares
    logic                   v4_reg;
    car_t                   car4_reg;
    logic [2:0][2*MN_W-1:0] sq4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq4_reg[i] <= car3_reg.mn[i] * car3_reg.mn[i];
            end
            car4_reg <= car3_reg;
        end
    end

    // Stage 5: sum of squares
    logic            v5_reg;
    car_t            car5_reg;
    logic [SQ_W-1:0] sum5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum5_reg <= SQ_W'(sq4_reg[0]) + SQ_W'(sq4_reg[1]) + SQ_W'(sq4_reg[2]);
            car5_reg <= car4_reg;
        end
    end

    // Square root: one root bit per stage, most significant first
    logic              sr_v_reg    [SQ_N];
    logic [SQ_W-1:0]   sr_rem_reg  [SQ_N];
    logic [ROOT_W-1:0] sr_root_reg [SQ_N];
    car_t              sr_car_reg  [SQ_N];

    for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
        localparam int K = SQ_N - 1 - j;
        logic              v_in;
        logic [SQ_W-1:0]   rem_in;
        logic [ROOT_W-1:0] root_in;
        car_t              car_in;
        logic [SQ_W-1:0]   trial;

        if (j == 0) begin : g_first
            assign v_in    = v5_reg;
            assign rem_in  = sum5_reg;
            assign root_in = '0;
            assign car_in  = car5_reg;
        end else begin : g_rest
            assign v_in    = sr_v_reg[j-1];
            assign rem_in  = sr_rem_reg[j-1];
            assign root_in = sr_root_reg[j-1];
            assign car_in  = sr_car_reg[j-1];
        end

        assign trial = (SQ_W'(root_in) << (K + 1)) + (SQ_W'(1) << (2 * K));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sr_v_reg[j] <= 1'b0;
            end else if (en) begin
                sr_v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_in >= trial) begin
                    sr_rem_reg[j]  <= rem_in - trial;
                    sr_root_reg[j] <= root_in | (ROOT_W'(1) << K);
                end else begin
                    sr_rem_reg[j]  <= rem_in;
                    sr_root_reg[j] <= root_in;
                end
                sr_car_reg[j] <= car_in;
            end
        end
    end

    // Division setup: numerator gets half the length for rounding
    logic                  dp_v_reg;
    logic [2:0][NUM_W-1:0] dp_num_reg;
    logic [ROOT_W-1:0]     dp_den_reg;
    car_t                  dp_car_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dp_v_reg <= 1'b0;
        end else if (en) begin
            dp_v_reg <= sr_v_reg[SQ_N-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dp_num_reg[i] <= (NUM_W'(sr_car_reg[SQ_N-1].mn[i]) << FB)
                               + NUM_W'(sr_root_reg[SQ_N-1] >> 1);
            end
            dp_den_reg <= sr_root_reg[SQ_N-1];
            dp_car_reg <= sr_car_reg[SQ_N-1];
        end
    end

    // Division: one quotient bit per stage for all three components
    logic                  dv_v_reg   [Q_W];
    logic [2:0][NUM_W-1:0] dv_rem_reg [Q_W];
    logic [2:0][Q_W-1:0]   dv_q_reg   [Q_W];
    logic [ROOT_W-1:0]     dv_den_reg [Q_W];
    car_t                  dv_car_reg [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_div
        localparam int K = Q_W - 1 - j;
        logic                  v_in;
        logic [2:0][NUM_W-1:0] rem_in;
        logic [2:0][Q_W-1:0]   q_in;
        logic [ROOT_W-1:0]     den_in;
        car_t                  car_in;
        logic [NUM_W-1:0]      dsh;

        if (j == 0) begin : g_first
            assign v_in   = dp_v_reg;
            assign rem_in = dp_num_reg;
            assign q_in   = '0;
            assign den_in = dp_den_reg;
            assign car_in = dp_car_reg;
        end else begin : g_rest
            assign v_in   = dv_v_reg[j-1];
            assign rem_in = dv_rem_reg[j-1];
            assign q_in   = dv_q_reg[j-1];
            assign den_in = dv_den_reg[j-1];
            assign car_in = dv_car_reg[j-1];
        end

        assign dsh = NUM_W'(den_in) << K;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[j] <= 1'b0;
            end else if (en) begin
                dv_v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    if (rem_in[i] >= dsh) begin
                        dv_rem_reg[j][i] <= rem_in[i] - dsh;
                        dv_q_reg[j][i]   <= q_in[i] | (Q_W'(1) << K);
                    end else begin
                        dv_rem_reg[j][i] <= rem_in[i];
                        dv_q_reg[j][i]   <= q_in[i];
                    end
                end
                dv_den_reg[j] <= den_in;
                dv_car_reg[j] <= car_in;
            end
        end
    end

    // Output: apply signs, force zero axis on zero length
    logic            out_v_reg;
    lavm_pkg::uvec_t unit_reg;
    logic            ok_reg;
    lavm_pkg::side_t side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= dv_v_reg[Q_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (dv_car_reg[Q_W-1].zero) begin
                    unit_reg[i] <= '0;
                end else if (dv_car_reg[Q_W-1].neg[i]) begin
                    unit_reg[i] <= -UNIT_W'(dv_q_reg[Q_W-1][i]);
                end else begin
                    unit_reg[i] <= UNIT_W'(dv_q_reg[Q_W-1][i]);
                end
            end
            ok_reg   <= !dv_car_reg[Q_W-1].zero;
            side_reg <= dv_car_reg[Q_W-1].side;
        end
    end

    assign out_valid = out_v_reg;
    assign out_unit  = unit_reg;
    assign out_ok    = ok_reg;
    assign out_side  = side_reg;

    // Checks
    `LAVM_ASSERT_IMPL(a_scale_range, aclk, aresetn, v3_reg && !car3_reg.zero, (car3_reg.mn[0][MN_W-1] || car3_reg.mn[1][MN_W-1] || car3_reg.mn[2][MN_W-1]), "scaled maximum not in top bit")
    `LAVM_ASSERT_IMPL(a_sqrt_rem, aclk, aresetn, sr_v_reg[SQ_N-1], (sr_rem_reg[SQ_N-1] <= (SQ_W'(sr_root_reg[SQ_N-1]) << 1)), "square root remainder too large")
    `LAVM_ASSERT_IMPL(a_div_rem, aclk, aresetn, dv_v_reg[Q_W-1] && !dv_car_reg[Q_W-1].zero, (dv_rem_reg[Q_W-1][0] < NUM_W'(dv_den_reg[Q_W-1])), "division remainder not below length")
    `LAVM_ASSERT_IMPL(a_zero_unit, aclk, aresetn, out_valid && !out_ok, (out_unit == '0), "zero length gave nonzero axis")

endmodule

// File: hdl/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// Look-at view matrix
// Builds the left-handed 4x4 view matrix from eye, target and up in signed
// fixed point and streams it out as four rows.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata: eye, target, up (9 x 32 bit)
//  m_        out  m_tvalid/m_tready  m_tdata: four words, m_tuser, m_tlast
//
//  Each camera update gives four row transfers; with m_tready held high the
//  output port gives one row per cycle, and no new update is taken before the
//  last row of the shown matrix. The path from input transfer to the first row
//  passes 110 stages in the two normalizers, mostly square root and division.
//  Reset clears all valid bits; a stalled output row holds the whole pipe.
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_defines.svh"

module look_at_view_matrix (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  logic [287:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // elem_a, elem_b, elem_c, elem_d
    output logic [127:0] m_tdata,
    // row_index[1:0], degenerate
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    localparam int WORD_W = lavm_pkg::WORD_W;
    localparam int UNIT_W = lavm_pkg::UNIT_W;
    localparam int UP_W   = lavm_pkg::UP_W;
    localparam int NV_W   = lavm_pkg::NV_W;
    localparam int DOT_W  = lavm_pkg::DOT_W;
    localparam int PC_W   = WORD_W + UNIT_W;
    localparam int FS_W   = 2 * UNIT_W;
    localparam int UE_W   = WORD_W + UP_W;

    logic       en;
    logic       mat_v_reg;
    logic [1:0] row_reg;

    // Whole pipe advances only when no matrix is shown or its last row is taken
    assign en       = !mat_v_reg || (m_tready && (row_reg == lavm_pkg::ROW_LAST));
    assign s_tready = en;

    // Input register
    logic         in_v_reg;
    logic [287:0] in_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (en) begin
            in_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_data_reg <= s_tdata;
        end
    end

    // Direction target minus eye
    logic            d_v_reg;
    lavm_pkg::nvec_t d_reg;
    lavm_pkg::side_t d_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_v_reg <= 1'b0;
        end else if (en) begin
            d_v_reg <= in_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                d_reg[i] <= NV_W'($signed(in_data_reg[WORD_W*(3+i) +: WORD_W]))
                          - NV_W'($signed(in_data_reg[WORD_W*i +: WORD_W]));
                d_side_reg.eye[i] <= in_data_reg[WORD_W*i +: WORD_W];
                d_side_reg.aux[i] <= in_data_reg[WORD_W*(6+i) +: WORD_W];
            end
            d_side_reg.ok <= 1'b1;
        end
    end

    // Forward axis
    logic            n1_v;
    lavm_pkg::uvec_t f_unit;
    logic            ok_f;
    lavm_pkg::side_t n1_side;

    lavm_norm u_norm_fwd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_v_reg),
        .in_vec    (d_reg),
        .in_side   (d_side_reg),
        .out_valid (n1_v),
        .out_unit  (f_unit),
        .out_ok    (ok_f),
        .out_side  (n1_side)
    );

    // Cross up x forward: products
    logic                   c1_v_reg;
    logic signed [PC_W-1:0] pc_reg [6];
    lavm_pkg::side_t        c1_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_v_reg <= 1'b0;
        end else if (en) begin
            c1_v_reg <= n1_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pc_reg[0] <= $signed(n1_side.aux[1]) * $signed(f_unit[2]);
            pc_reg[1] <= $signed(n1_side.aux[2]) * $signed(f_unit[1]);
            pc_reg[2] <= $signed(n1_side.aux[2]) * $signed(f_unit[0]);
            pc_reg[3] <= $signed(n1_side.aux[0]) * $signed(f_unit[2]);
            pc_reg[4] <= $signed(n1_side.aux[0]) * $signed(f_unit[1]);
            pc_reg[5] <= $signed(n1_side.aux[1]) * $signed(f_unit[0]);
            c1_side_reg.ok  <= ok_f;
            c1_side_reg.eye <= n1_side.eye;
            for (int i = 0; i < 3; i++) begin
                c1_side_reg.aux[i] <= WORD_W'($signed(f_unit[i]));
            end
        end
    end

    // Cross product differences
    logic            c2_v_reg;
    lavm_pkg::nvec_t c2_reg;
    lavm_pkg::side_t c2_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c2_v_reg <= 1'b0;
        end else if (en) begin
            c2_v_reg <= c1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c2_reg[0]   <= NV_W'(pc_reg[0] - pc_reg[1]);
            c2_reg[1]   <= NV_W'(pc_reg[2] - pc_reg[3]);
            c2_reg[2]   <= NV_W'(pc_reg[4] - pc_reg[5]);
            c2_side_reg <= c1_side_reg;
        end
    end

    // Side axis
    logic            n2_v;
    lavm_pkg::uvec_t s_unit;
    logic            ok_s;
    lavm_pkg::side_t n2_side;

    lavm_norm u_norm_side (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c2_v_reg),
        .in_vec    (c2_reg),
        .in_side   (c2_side_reg),
        .out_valid (n2_v),
        .out_unit  (s_unit),
        .out_ok    (ok_s),
        .out_side  (n2_side)
    );

    // Products for true up and the side and forward dot products
    logic                     u1_v_reg;
    logic signed [FS_W-1:0]   pfs_reg [6];
    logic signed [PC_W-1:0]   pse_reg [3];
    logic signed [PC_W-1:0]   pfe_reg [3];
    logic signed [UNIT_W-1:0] s1_reg  [3];
    logic signed [UNIT_W-1:0] f1_reg  [3];
    logic signed [WORD_W-1:0] eye1_reg [3];
    logic                     deg1_reg;
    logic signed [UNIT_W-1:0] f_in [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            f_in[i] = $signed(n2_side.aux[i][UNIT_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u1_v_reg <= 1'b0;
        end else if (en) begin
            u1_v_reg <= n2_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pfs_reg[0] <= f_in[1] * $signed(s_unit[2]);
            pfs_reg[1] <= f_in[2] * $signed(s_unit[1]);
            pfs_reg[2] <= f_in[2] * $signed(s_unit[0]);
            pfs_reg[3] <= f_in[0] * $signed(s_unit[2]);
            pfs_reg[4] <= f_in[0] * $signed(s_unit[1]);
            pfs_reg[5] <= f_in[1] * $signed(s_unit[0]);
            for (int i = 0; i < 3; i++) begin
                pse_reg[i]  <= $signed(s_unit[i]) * $signed(n2_side.eye[i]);
                pfe_reg[i]  <= f_in[i] * $signed(n2_side.eye[i]);
                s1_reg[i]   <= $signed(s_unit[i]);
                f1_reg[i]   <= f_in[i];
                eye1_reg[i] <= $signed(n2_side.eye[i]);
            end
            deg1_reg <= !(n2_side.ok && ok_s);
        end
    end

    // Differences and sums
    logic                     u2_v_reg;
    logic signed [DOT_W-1:0]  ucr_reg [3];
    logic signed [DOT_W-1:0]  dse_reg;
    logic signed [DOT_W-1:0]  dfe_reg;
    logic signed [UNIT_W-1:0] s2_reg  [3];
    logic signed [UNIT_W-1:0] f2_reg  [3];
    logic signed [WORD_W-1:0] eye2_reg [3];
    logic                     deg2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u2_v_reg <= 1'b0;
        end else if (en) begin
            u2_v_reg <= u1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ucr_reg[0] <= DOT_W'(pfs_reg[0] - pfs_reg[1]);
            ucr_reg[1] <= DOT_W'(pfs_reg[2] - pfs_reg[3]);
            ucr_reg[2] <= DOT_W'(pfs_reg[4] - pfs_reg[5]);
            dse_reg    <= DOT_W'(pse_reg[0]) + DOT_W'(pse_reg[1]) + DOT_W'(pse_reg[2]);
            dfe_reg    <= DOT_W'(pfe_reg[0]) + DOT_W'(pfe_reg[1]) + DOT_W'(pfe_reg[2]);
            s2_reg     <= s1_reg;
            f2_reg     <= f1_reg;
            eye2_reg   <= eye1_reg;
            deg2_reg   <= deg1_reg;
        end
    end

    // Round true up; finish side and forward translations
    logic                     u3_v_reg;
    logic signed [UP_W-1:0]   u3_reg  [3];
    logic [WORD_W-1:0]        trs3_reg;
    logic [WORD_W-1:0]        trf3_reg;
    logic signed [UNIT_W-1:0] s3_reg  [3];
    logic signed [UNIT_W-1:0] f3_reg  [3];
    logic signed [WORD_W-1:0] eye3_reg [3];
    logic                     deg3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u3_v_reg <= 1'b0;
        end else if (en) begin
            u3_v_reg <= u2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                u3_reg[i] <= UP_W'(lavm_pkg::rnd_shift(ucr_reg[i]));
            end
            trs3_reg <= lavm_pkg::neg_sat(dse_reg);
            trf3_reg <= lavm_pkg::neg_sat(dfe_reg);
            s3_reg   <= s2_reg;
            f3_reg   <= f2_reg;
            eye3_reg <= eye2_reg;
            deg3_reg <= deg2_reg;
        end
    end

    // True up times eye
    logic                     u4_v_reg;
    logic signed [UE_W-1:0]   pue_reg [3];
    logic signed [UP_W-1:0]   u4_reg  [3];
    logic [WORD_W-1:0]        trs4_reg;
    logic [WORD_W-1:0]        trf4_reg;
    logic signed [UNIT_W-1:0] s4_reg  [3];
    logic signed [UNIT_W-1:0] f4_reg  [3];
    logic                     deg4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u4_v_reg <= 1'b0;
        end else if (en) begin
            u4_v_reg <= u3_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                pue_reg[i] <= u3_reg[i] * eye3_reg[i];
            end
            u4_reg   <= u3_reg;
            trs4_reg <= trs3_reg;
            trf4_reg <= trf3_reg;
            s4_reg   <= s3_reg;
            f4_reg   <= f3_reg;
            deg4_reg <= deg3_reg;
        end
    end

    // True up dot sum
    logic                     u5_v_reg;
    logic signed [DOT_W-1:0]  due_reg;
    logic signed [UP_W-1:0]   u5_reg  [3];
    logic [WORD_W-1:0]        trs5_reg;
    logic [WORD_W-1:0]        trf5_reg;
    logic signed [UNIT_W-1:0] s5_reg  [3];
    logic signed [UNIT_W-1:0] f5_reg  [3];
    logic                     deg5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u5_v_reg <= 1'b0;
        end else if (en) begin
            u5_v_reg <= u4_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            due_reg  <= DOT_W'(pue_reg[0]) + DOT_W'(pue_reg[1]) + DOT_W'(pue_reg[2]);
            u5_reg   <= u4_reg;
            trs5_reg <= trs4_reg;
            trf5_reg <= trf4_reg;
            s5_reg   <= s4_reg;
            f5_reg   <= f4_reg;
            deg5_reg <= deg4_reg;
        end
    end

    // Matrix register and row sequencer
    logic signed [UNIT_W-1:0] ms_reg [3];
    logic signed [UP_W-1:0]   mu_reg [3];
    logic signed [UNIT_W-1:0] mf_reg [3];
    logic [WORD_W-1:0]        mtr_reg [3];
    logic                     mdeg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_v_reg <= 1'b0;
            row_reg   <= lavm_pkg::ROW_X;
        end else if (en) begin
            mat_v_reg <= u5_v_reg;
            row_reg   <= lavm_pkg::ROW_X;
        end else if (m_tvalid && m_tready) begin
            row_reg <= row_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ms_reg     <= s5_reg;
            mu_reg     <= u5_reg;
            mf_reg     <= f5_reg;
            mtr_reg[0] <= trs5_reg;
            mtr_reg[1] <= lavm_pkg::neg_sat(due_reg);
            mtr_reg[2] <= trf5_reg;
            mdeg_reg   <= deg5_reg;
        end
    end

    // Select the current row
    logic [WORD_W-1:0] elem_a;
    logic [WORD_W-1:0] elem_b;
    logic [WORD_W-1:0] elem_c;
    logic [WORD_W-1:0] elem_d;

    always_comb begin
        elem_d = '0;
        case (row_reg)
            lavm_pkg::ROW_X: begin
                elem_a = WORD_W'(ms_reg[0]);
                elem_b = WORD_W'(mu_reg[0]);
                elem_c = WORD_W'(mf_reg[0]);
            end
            lavm_pkg::ROW_Y: begin
                elem_a = WORD_W'(ms_reg[1]);
                elem_b = WORD_W'(mu_reg[1]);
                elem_c = WORD_W'(mf_reg[1]);
            end
            lavm_pkg::ROW_Z: begin
                elem_a = WORD_W'(ms_reg[2]);
                elem_b = WORD_W'(mu_reg[2]);
                elem_c = WORD_W'(mf_reg[2]);
            end
            default: begin
                elem_a = mtr_reg[0];
                elem_b = mtr_reg[1];
                elem_c = mtr_reg[2];
                elem_d = WORD_W'(1) << lavm_pkg::FRAC_BITS;
            end
        endcase
    end

    assign m_tvalid = mat_v_reg;
    assign m_tdata  = {elem_d, elem_c, elem_b, elem_a};
    assign m_tuser  = {mdeg_reg, row_reg};
    assign m_tlast  = (row_reg == lavm_pkg::ROW_LAST);

    // Checks
    `LAVM_ASSERT_NEXT(a_row_step, aclk, aresetn, m_tvalid && m_tready && !m_tlast, (m_tvalid && (row_reg == $past(row_reg) + 2'd1)), "row did not advance after transfer")
    `LAVM_ASSERT_NEXT(a_matrix_hold, aclk, aresetn, m_tvalid && !m_tlast, ($stable(mdeg_reg) && $stable(mtr_reg[1])), "matrix changed inside its rows")
    `LAVM_ASSERT_NEXT(a_drain, aclk, aresetn, m_tvalid && m_tready && m_tlast && !u5_v_reg, !m_tvalid, "row shown after matrix drained")
    `LAVM_ASSERT_IMPL(a_ready_free, aclk, aresetn, !m_tvalid, s_tready, "input stalled with empty output")

endmodule
